[src/timed_event_queue_macros.svh]
// ----------------------------------------------------------------------------
// timed_event_queue_macros
// Assertion macros used by the event queue checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, reset masked
`define TEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timed_event_queue assertion failed");

// next-cycle implication, reset masked
`define TEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timed_event_queue assertion failed");

`endif

[src/teq_pkg.sv]
// ----------------------------------------------------------------------------
// teq_pkg
// Types, constants and codes shared by the event queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);

  localparam int KIND_W    = 3;
  localparam int TIME_W    = 64;
  localparam int PRIO_W    = 8;
  localparam int HANDLER_W = 16;
  localparam int CONTEXT_W = 32;
  localparam int ID_W      = 32;
  localparam int ORDER_W   = 32;
  localparam int KEY_W     = TIME_W + PRIO_W + ORDER_W;

  localparam logic [KIND_W-1:0] KIND_SCHEDULE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_NEXT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_UNTIL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } teq_state_t;

  typedef struct packed {
    logic load;
    logic scan_issue;
    logic finish;
  } teq_cmd_t;

  typedef struct packed {
    logic scan_last;
  } teq_sts_t;

  typedef struct packed {
    logic [TIME_W-1:0]    time_value;
    logic [PRIO_W-1:0]    priority_level;
    logic [ORDER_W-1:0]   order;
    logic [ID_W-1:0]      id;
    logic [HANDLER_W-1:0] handler;
    logic [CONTEXT_W-1:0] context_tag;
  } teq_slot_t;

endpackage

`default_nettype wire

[src/teq_ctrl.sv]
// ----------------------------------------------------------------------------
// teq_ctrl
// Controller: sequences load, slot scan and finish, owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [teq_pkg::KIND_W-1:0] in_kind,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire teq_pkg::teq_sts_t         sts,
  output teq_pkg::teq_cmd_t              cmd
);
  import teq_pkg::*;

  teq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CANCEL || in_kind == KIND_POP_NEXT ||
              in_kind == KIND_POP_UNTIL) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    cmd.load       = in_valid && (state_r == ST_IDLE);
    cmd.scan_issue = (state_r == ST_SCAN);
    cmd.finish     = (state_r == ST_DONE) && out_free;
    out_valid_nxt  = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[src/teq_dpath.sv]
// ----------------------------------------------------------------------------
// teq_dpath
// Datapath: slot memory, live bits, scan compare, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire teq_pkg::teq_cmd_t             cmd,
  output teq_pkg::teq_sts_t                  sts,
  input  wire logic [teq_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [teq_pkg::TIME_W-1:0]    in_time_value,
  input  wire logic [teq_pkg::PRIO_W-1:0]    in_priority_level,
  input  wire logic [teq_pkg::HANDLER_W-1:0] in_handler_tag,
  input  wire logic [teq_pkg::CONTEXT_W-1:0] in_context_tag,
  input  wire logic [teq_pkg::ID_W-1:0]      in_cancel_id,
  output logic                               out_result_ok,
  output logic [teq_pkg::ID_W-1:0]           out_new_event_id,
  output logic [teq_pkg::TIME_W-1:0]         out_fired_time,
  output logic [teq_pkg::HANDLER_W-1:0]      out_fired_handler,
  output logic [teq_pkg::CONTEXT_W-1:0]      out_fired_context,
  output logic [teq_pkg::TIME_W-1:0]         out_current_time
);
  import teq_pkg::*;

  teq_slot_t              mem [QUEUE_SLOTS];
  teq_slot_t              rd_r;

  logic [KIND_W-1:0]      op_kind_r;
  logic [TIME_W-1:0]      op_time_r;
  logic [PRIO_W-1:0]      op_prio_r;
  logic [HANDLER_W-1:0]   op_handler_r;
  logic [CONTEXT_W-1:0]   op_context_r;
  logic [ID_W-1:0]        op_cid_r;

  logic [SLOT_W-1:0]      scan_idx_r;
  logic                   cmp_vld_r;
  logic                   cmp_live_r;
  logic [SLOT_W-1:0]      cmp_idx_r;

  logic                   best_found_r;
  logic [SLOT_W-1:0]      best_idx_r;
  logic [TIME_W-1:0]      best_time_r;
  logic [PRIO_W-1:0]      best_prio_r;
  logic [ORDER_W-1:0]     best_order_r;
  logic [HANDLER_W-1:0]   best_handler_r;
  logic [CONTEXT_W-1:0]   best_context_r;

  logic [QUEUE_SLOTS-1:0] valid_r, valid_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [ID_W-1:0]        id_ctr_r, id_ctr_nxt, id_inc;
  logic [ORDER_W-1:0]     order_ctr_r, order_ctr_nxt;

  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   take;
  logic                   fire;
  logic                   wr_en;

  logic                   res_ok;
  logic [ID_W-1:0]        res_id;
  logic [TIME_W-1:0]      res_time;
  logic [HANDLER_W-1:0]   res_handler;
  logic [CONTEXT_W-1:0]   res_context;

  logic                   out_ok_r;
  logic [ID_W-1:0]        out_id_r;
  logic [TIME_W-1:0]      out_time_r;
  logic [HANDLER_W-1:0]   out_handler_r;
  logic [CONTEXT_W-1:0]   out_context_r;
  logic [TIME_W-1:0]      out_now_r;

  assign sts.scan_last = (scan_idx_r == SLOT_W'(QUEUE_SLOTS - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    logic [KEY_W-1:0] cand_key;
    logic [KEY_W-1:0] best_key;
    cand_key = {rd_r.time_value, rd_r.priority_level, rd_r.order};
    best_key = {best_time_r, best_prio_r, best_order_r};
    take     = 1'b0;
    if (cmp_vld_r && cmp_live_r) begin
      if (op_kind_r == KIND_CANCEL) begin
        take = !best_found_r && (op_cid_r != '0) && (rd_r.id == op_cid_r);
      end else begin
        take = !best_found_r || (cand_key < best_key);
      end
    end
  end

  assign id_inc = id_ctr_r + ID_W'(1);
  assign fire   = best_found_r &&
                  ((op_kind_r == KIND_POP_NEXT) || (best_time_r <= op_time_r));

  always_comb begin
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    id_ctr_nxt    = id_ctr_r;
    order_ctr_nxt = order_ctr_r;
    wr_en         = 1'b0;
    res_ok        = 1'b0;
    res_id        = '0;
    res_time      = '0;
    res_handler   = '0;
    res_context   = '0;
    case (op_kind_r)
      KIND_SCHEDULE: begin
        if (free_found) begin
          wr_en               = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          res_ok              = 1'b1;
          res_id              = id_ctr_r;
          order_ctr_nxt       = order_ctr_r + ORDER_W'(1);
          id_ctr_nxt          = (id_inc == '0) ? ID_W'(1) : id_inc;
        end
      end
      KIND_CANCEL: begin
        if (best_found_r) begin
          valid_nxt[best_idx_r] = 1'b0;
          res_ok                = 1'b1;
        end
      end
      KIND_POP_NEXT, KIND_POP_UNTIL: begin
        if (fire) begin
          valid_nxt[best_idx_r] = 1'b0;
          res_ok                = 1'b1;
          res_time              = best_time_r;
          res_handler           = best_handler_r;
          res_context           = best_context_r;
          if (best_time_r > now_r) begin
            now_nxt = best_time_r;
          end
        end else if (op_kind_r == KIND_POP_UNTIL && op_time_r > now_r) begin
          now_nxt = op_time_r;
        end
      end
      KIND_CLEAR: begin
        valid_nxt     = '0;
        now_nxt       = '0;
        id_ctr_nxt    = ID_W'(1);
        order_ctr_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[free_idx] <= '{time_value:     op_time_r,
                         priority_level: op_prio_r,
                         order:          order_ctr_r,
                         id:             id_ctr_r,
                         handler:        op_handler_r,
                         context_tag:    op_context_r};
    end
    rd_r <= mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind_r    <= in_kind;
      op_time_r    <= in_time_value;
      op_prio_r    <= in_priority_level;
      op_handler_r <= in_handler_tag;
      op_context_r <= in_context_tag;
      op_cid_r     <= in_cancel_id;
    end
    cmp_live_r <= valid_r[scan_idx_r];
    cmp_idx_r  <= scan_idx_r;
    if (take) begin
      best_idx_r     <= cmp_idx_r;
      best_time_r    <= rd_r.time_value;
      best_prio_r    <= rd_r.priority_level;
      best_order_r   <= rd_r.order;
      best_handler_r <= rd_r.handler;
      best_context_r <= rd_r.context_tag;
    end
    if (cmd.finish) begin
      out_ok_r      <= res_ok;
      out_id_r      <= res_id;
      out_time_r    <= res_time;
      out_handler_r <= res_handler;
      out_context_r <= res_context;
      out_now_r     <= now_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      valid_r      <= '0;
      now_r        <= '0;
      id_ctr_r     <= ID_W'(1);
      order_ctr_r  <= '0;
    end else begin
      cmp_vld_r <= cmd.scan_issue;
      if (cmd.load) begin
        scan_idx_r   <= '0;
        best_found_r <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          scan_idx_r <= scan_idx_r + SLOT_W'(1);
        end
        if (take) begin
          best_found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        valid_r     <= valid_nxt;
        now_r       <= now_nxt;
        id_ctr_r    <= id_ctr_nxt;
        order_ctr_r <= order_ctr_nxt;
      end
    end
  end

  assign out_result_ok     = out_ok_r;
  assign out_new_event_id  = out_id_r;
  assign out_fired_time    = out_time_r;
  assign out_fired_handler = out_handler_r;
  assign out_fired_context = out_context_r;
  assign out_current_time  = out_now_r;

endmodule

`default_nettype wire

[src/timed_event_queue.sv]
// ----------------------------------------------------------------------------
// timed_event_queue
// Virtual-time event queue: schedule, cancel, pop-next, pop-until and clear.
// ----------------------------------------------------------------------------
// One item is in work at a time. Cancel, pop-next and pop-until run a scan
// that reads one slot per cycle from the slot memory and compares it against
// the best candidate so far. Schedule, clear and unused kinds skip the scan;
// the free slot comes from the live bits directly. A finished result sits in
// the output register, and the next item is transferred in while that result
// waits.
`default_nettype none

module timed_event_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [teq_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [teq_pkg::TIME_W-1:0]    in_time_value,
  input  wire logic [teq_pkg::PRIO_W-1:0]    in_priority_level,
  input  wire logic [teq_pkg::HANDLER_W-1:0] in_handler_tag,
  input  wire logic [teq_pkg::CONTEXT_W-1:0] in_context_tag,
  input  wire logic [teq_pkg::ID_W-1:0]      in_cancel_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_result_ok,
  output logic [teq_pkg::ID_W-1:0]           out_new_event_id,
  output logic [teq_pkg::TIME_W-1:0]         out_fired_time,
  output logic [teq_pkg::HANDLER_W-1:0]      out_fired_handler,
  output logic [teq_pkg::CONTEXT_W-1:0]      out_fired_context,
  output logic [teq_pkg::TIME_W-1:0]         out_current_time
);
  import teq_pkg::*;

  teq_cmd_t cmd;
  teq_sts_t sts;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  teq_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_time_value     (in_time_value),
    .in_priority_level (in_priority_level),
    .in_handler_tag    (in_handler_tag),
    .in_context_tag    (in_context_tag),
    .in_cancel_id      (in_cancel_id),
    .out_result_ok     (out_result_ok),
    .out_new_event_id  (out_new_event_id),
    .out_fired_time    (out_fired_time),
    .out_fired_handler (out_fired_handler),
    .out_fired_context (out_fired_context),
    .out_current_time  (out_current_time)
  );

endmodule

`default_nettype wire

[src/teq_checker.sv]
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks on the event queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_event_queue_macros.svh"

module teq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_result_ok,
  input wire logic [teq_pkg::ID_W-1:0]      out_new_event_id,
  input wire logic [teq_pkg::TIME_W-1:0]    out_fired_time,
  input wire logic [teq_pkg::TIME_W-1:0]    out_current_time
);
  import teq_pkg::*;

  `TEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TEQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `TEQ_ASSERT_NOW(a_id_means_ok, out_valid && out_new_event_id != '0, out_result_ok)
  `TEQ_ASSERT_NOW(a_fire_not_ahead, out_valid && out_result_ok, out_fired_time <= out_current_time)

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);

`default_nettype wire
